@@ rtl/core/stack_queue_engine_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Stack/queue engine assertion macros
// Shared concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STACK_QUEUE_ENGINE_UNIT_MACROS_SVH
`define STACK_QUEUE_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTH
`define SQE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SQE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SQE_ASSERT_IMP(lbl, ante, cons, msg)
`define SQE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/sqe_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack/queue engine package
// Transaction payload types, operation and status codes, and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package sqe_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned FILL_W = 7;

	localparam logic [2:0] MODE_PUSH = 3'd0;
	localparam logic [2:0] MODE_POP = 3'd1;
	localparam logic [2:0] MODE_PEEK = 3'd2;
	localparam logic [2:0] MODE_SWAP = 3'd3;
	localparam logic [2:0] MODE_PRINT = 3'd4;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_SHORT = 2'd2;
	localparam logic [1:0] STATUS_FULL = 2'd3;

	typedef struct packed {
		logic [2:0] mode;
		logic signed [VALUE_W-1:0] value;
	} sqe_in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] data;
		logic [1:0] status;
		logic last;
		logic [FILL_W-1:0] fill;
	} sqe_out_t;

	typedef enum logic [1:0] {
		RD_FRONT = 2'd0,
		RD_SECOND = 2'd1,
		RD_WALK = 2'd2
	} sqe_rd_sel_t;

	typedef enum logic [1:0] {
		WR_PUSH = 2'd0,
		WR_SWAP_FRONT = 2'd1,
		WR_SWAP_SECOND = 2'd2
	} sqe_wr_sel_t;

	typedef struct packed {
		logic load_op;
		logic commit_push;
		logic commit_pop;
		logic rd_en;
		sqe_rd_sel_t rd_sel;
		logic wr_en;
		sqe_wr_sel_t wr_sel;
		logic save_tmp;
		logic walk_init;
		logic walk_step;
		logic emit;
		logic emit_rdata;
		logic [1:0] status;
		logic last;
	} sqe_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic empty;
		logic full;
		logic short_cnt;
		logic walk_last;
		logic out_free;
	} sqe_stat_t;

endpackage

@@ rtl/core/sqe_dpath.sv @@
// ----------------------------------------------------------------------------
// Stack/queue engine datapath
// Entry memory, front pointer and count, print walker, and output register.
// ----------------------------------------------------------------------------
module sqe_dpath import sqe_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  sqe_in_t   in_data,
	input  sqe_cmd_t  cmd,
	output sqe_stat_t stat,
	input  logic      out_ready,
	output logic      out_valid,
	output sqe_out_t  out_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
		return (a == LAST_ADDR) ? '0 : AW'(a + 1'b1);
	endfunction

	function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
		return (a == '0) ? LAST_ADDR : AW'(a - 1'b1);
	endfunction

	logic [VALUE_W-1:0] mem [DEPTH];

	sqe_in_t            op_q;
	logic               queue_order_q;
	logic [AW-1:0]      front_q;
	logic [CW-1:0]      count_q;
	logic [VALUE_W-1:0] rdata_q;
	logic [VALUE_W-1:0] tmp_q;
	logic [AW-1:0]      walk_addr_q;
	logic [CW-1:0]      remain_q;
	logic               out_valid_q;
	sqe_out_t           out_q;

	logic [AW-1:0]      front_d;
	logic [CW-1:0]      count_d;
	logic [AW:0]        back_sum;
	logic [AW-1:0]      back_addr;
	logic [AW-1:0]      wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic [AW-1:0]      rd_addr;
	logic               out_free;

	assign back_sum = {1'b0, front_q} + (AW + 1)'(count_q);
	assign back_addr = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : back_sum[AW-1:0];
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		if (cmd.commit_push) begin
			count_d = CW'(count_q + 1'b1);
			if (!queue_order_q) begin
				front_d = addr_dec(front_q);
			end
		end else if (cmd.commit_pop) begin
			count_d = CW'(count_q - 1'b1);
			front_d = addr_inc(front_q);
		end
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_PUSH: begin
				wr_addr = queue_order_q ? back_addr : addr_dec(front_q);
				wr_data = op_q.value;
			end
			WR_SWAP_FRONT: begin
				wr_addr = front_q;
				wr_data = rdata_q;
			end
			WR_SWAP_SECOND: begin
				wr_addr = addr_inc(front_q);
				wr_data = tmp_q;
			end
			default: begin
				wr_addr = front_q;
				wr_data = op_q.value;
			end
		endcase
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_FRONT:  rd_addr = front_q;
			RD_SECOND: rd_addr = addr_inc(front_q);
			RD_WALK:   rd_addr = walk_addr_q;
			default:   rd_addr = front_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			op_q <= in_data;
		end
		if (cmd.save_tmp) begin
			tmp_q <= rdata_q;
		end
		if (cmd.walk_init) begin
			walk_addr_q <= addr_inc(front_q);
			remain_q <= count_q;
		end else if (cmd.walk_step) begin
			walk_addr_q <= addr_inc(walk_addr_q);
			remain_q <= CW'(remain_q - 1'b1);
		end
		if (cmd.emit) begin
			out_q.data <= cmd.emit_rdata ? rdata_q : '0;
			out_q.status <= cmd.status;
			out_q.last <= cmd.last;
			out_q.fill <= FILL_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_order_q <= 1'b0;
			front_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				queue_order_q <= cfg_wdata;
			end
			front_q <= front_d;
			count_q <= count_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.mode = op_q.mode;
	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == FULL_CNT);
	assign stat.short_cnt = (count_q < CW'(2));
	assign stat.walk_last = (remain_q == CW'(1));
	assign stat.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`include "stack_queue_engine_unit_macros.svh"

	`SQE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= FULL_CNT, "Entry count exceeds depth.")
	`SQE_ASSERT_IMP(a_push_not_full, cmd.commit_push, !stat.full && cmd.wr_en, "Push committed into a full store.")
	`SQE_ASSERT_IMP(a_emit_room, cmd.emit, out_free, "Result emitted over a pending transaction.")

endmodule

@@ rtl/core/sqe_ctrl.sv @@
// ----------------------------------------------------------------------------
// Stack/queue engine controller
// Sequences each operation over the datapath and issues its results.
// ----------------------------------------------------------------------------
module sqe_ctrl import sqe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sqe_stat_t stat,
	output sqe_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_PEEK = 7'b0000100,
		S_SW1  = 7'b0001000,
		S_SW2  = 7'b0010000,
		S_SW3  = 7'b0100000,
		S_WALK = 7'b1000000
	} sqe_state_t;

	sqe_state_t state_q;
	sqe_state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_op = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.mode)
					MODE_PUSH: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							if (stat.full) begin
								cmd.status = STATUS_FULL;
							end else begin
								cmd.status = STATUS_OK;
								cmd.commit_push = 1'b1;
								cmd.wr_en = 1'b1;
								cmd.wr_sel = WR_PUSH;
							end
							state_d = S_IDLE;
						end
					end
					MODE_POP: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							if (stat.empty) begin
								cmd.status = STATUS_EMPTY;
							end else begin
								cmd.status = STATUS_OK;
								cmd.commit_pop = 1'b1;
							end
							state_d = S_IDLE;
						end
					end
					MODE_PEEK: begin
						if (stat.empty) begin
							if (stat.out_free) begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
								cmd.status = STATUS_EMPTY;
								state_d = S_IDLE;
							end
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = RD_FRONT;
							state_d = S_PEEK;
						end
					end
					MODE_SWAP: begin
						if (stat.short_cnt) begin
							if (stat.out_free) begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
								cmd.status = STATUS_SHORT;
								state_d = S_IDLE;
							end
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = RD_FRONT;
							state_d = S_SW1;
						end
					end
					MODE_PRINT: begin
						if (stat.empty) begin
							state_d = S_IDLE;
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = RD_FRONT;
							cmd.walk_init = 1'b1;
							state_d = S_WALK;
						end
					end
					default: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							cmd.status = STATUS_OK;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_PEEK: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_rdata = 1'b1;
					cmd.last = 1'b1;
					cmd.status = STATUS_OK;
					state_d = S_IDLE;
				end
			end
			S_SW1: begin
				cmd.save_tmp = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_SECOND;
				state_d = S_SW2;
			end
			S_SW2: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WR_SWAP_FRONT;
				state_d = S_SW3;
			end
			S_SW3: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WR_SWAP_SECOND;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					cmd.status = STATUS_OK;
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_rdata = 1'b1;
					cmd.status = STATUS_OK;
					cmd.last = stat.walk_last;
					if (stat.walk_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_en = 1'b1;
						cmd.rd_sel = RD_WALK;
						cmd.walk_step = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`include "stack_queue_engine_unit_macros.svh"

	`SQE_ASSERT_NXT(a_accept_exec, in_valid && in_ready, state_q == S_EXEC, "Accepted transaction did not start execution.")

endmodule

@@ rtl/core/stack_queue_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Stack/queue engine
// Bounded store of signed 32-bit entries working as a stack or a queue.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  cfg     | in        | cfg_we                | cfg_wdata (queue order)
//  in      | in        | in_valid / in_ready   | sqe_in_t  (mode, value)
//  out     | out       | out_valid / out_ready | sqe_out_t (data, status, last, fill)
//
// One operation is in flight at a time; a new transaction is taken in the idle state.
// Push, pop and error results are issued straight from the execute state; peek and
// swap first use the registered read of the entry memory, and swap writes both top entries back crossed.
// Print-all emits one result per held entry, one entry per cycle while the output is not stalled.
// A stalled output holds the controller in any state that emits; reset empties the store at once.
module stack_queue_engine_unit import sqe_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	input  logic     in_valid,
	output logic     in_ready,
	input  sqe_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output sqe_out_t out_data
);

	sqe_cmd_t  cmd;
	sqe_stat_t stat;

	sqe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sqe_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Stack/queue engine testbench
// Drives operations into the engine through its input handshake and follows
// every transaction with a shadow copy of the store, in both stack and queue
// order. A short table of directed operations exercises the empty, short,
// unused-mode and extreme-value cases. Random phases follow: they fill the
// store to the top, drain it, and mix all operations, with random idle
// cycles on either side in some phases. Each result is checked field by field against the
// oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sqe_pkg::*;

	localparam int unsigned STORE_DEPTH = 64;
	localparam int NUM_DIR = 25;
	localparam int QUIET_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;

	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	typedef struct packed {
		sqe_in_t op;
		logic pinned;
		sqe_out_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic in_valid;
	logic in_ready;
	sqe_in_t in_data;
	logic out_valid;
	logic out_ready;
	sqe_out_t out_data;

	logic pin_on;
	sqe_out_t pin_res;
	bit src_idle;
	bit sink_idle;

	logic [31:0] shadow_entries [STORE_DEPTH];
	logic [5:0] shadow_front;
	logic [6:0] shadow_count;
	logic shadow_queue_order;
	sqe_out_t step_res [STORE_DEPTH];
	sqe_out_t owed_results [$];

	int n_bad = 0;
	int n_ops = 0;
	int n_results = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_short = 0;
	int n_print = 0;
	int peak_fill = 0;

	stack_queue_engine_unit #(
		.DEPTH(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #4 clk = ~clk;

	function automatic sqe_out_t make_result(input logic [31:0] d, input logic [1:0] st,
			input logic lst);
		sqe_out_t r;
		r.data = d;
		r.status = st;
		r.last = lst;
		r.fill = shadow_count;
		return r;
	endfunction

	// Applies one operation to the shadow store and returns how many results it owes.
	function automatic int apply_store_op(input sqe_in_t op);
		logic [5:0] pos;
		logic [31:0] tmp;
		int i;
		case (op.mode)
		MODE_PUSH: begin
			if (shadow_count == 7'(STORE_DEPTH)) begin
				step_res[0] = make_result('0, STATUS_FULL, 1'b1);
			end else begin
				if (shadow_queue_order) begin
					pos = shadow_front + shadow_count[5:0];
					shadow_entries[pos] = op.value;
				end else begin
					shadow_front = shadow_front - 6'd1;
					shadow_entries[shadow_front] = op.value;
				end
				shadow_count = shadow_count + 7'd1;
				step_res[0] = make_result('0, STATUS_OK, 1'b1);
			end
			return 1;
		end
		MODE_POP: begin
			if (shadow_count == '0) begin
				step_res[0] = make_result('0, STATUS_EMPTY, 1'b1);
			end else begin
				shadow_front = shadow_front + 6'd1;
				shadow_count = shadow_count - 7'd1;
				step_res[0] = make_result('0, STATUS_OK, 1'b1);
			end
			return 1;
		end
		MODE_PEEK: begin
			if (shadow_count == '0) begin
				step_res[0] = make_result('0, STATUS_EMPTY, 1'b1);
			end else begin
				step_res[0] = make_result(shadow_entries[shadow_front], STATUS_OK, 1'b1);
			end
			return 1;
		end
		MODE_SWAP: begin
			if (shadow_count < 7'd2) begin
				step_res[0] = make_result('0, STATUS_SHORT, 1'b1);
			end else begin
				pos = shadow_front + 6'd1;
				tmp = shadow_entries[shadow_front];
				shadow_entries[shadow_front] = shadow_entries[pos];
				shadow_entries[pos] = tmp;
				step_res[0] = make_result('0, STATUS_OK, 1'b1);
			end
			return 1;
		end
		MODE_PRINT: begin
			for (i = 0; i < int'(shadow_count); i++) begin
				pos = shadow_front + 6'(i);
				step_res[i] = make_result(shadow_entries[pos], STATUS_OK,
					i == int'(shadow_count) - 1);
			end
			return int'(shadow_count);
		end
		default: begin
			step_res[0] = make_result('0, STATUS_OK, 1'b1);
			return 1;
		end
		endcase
	endfunction

	always @(posedge clk) begin
		sqe_out_t want;
		int n;
		if (arst_n) begin
			if (cfg_we) begin
				shadow_queue_order = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					$error("unexpected result: data %0d status %0d last %0d fill %0d",
						out_data.data, out_data.status, out_data.last, out_data.fill);
					n_bad++;
				end else begin
					want = owed_results.pop_front();
					if (out_data.data !== want.data) begin
						$error("data: expected %0d, got %0d", want.data, out_data.data);
						n_bad++;
					end
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_data.status);
						n_bad++;
					end
					if (out_data.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_data.last);
						n_bad++;
					end
					if (out_data.fill !== want.fill) begin
						$error("fill: expected %0d, got %0d", want.fill, out_data.fill);
						n_bad++;
					end
					n_results++;
					case (want.status)
					STATUS_FULL: n_full++;
					STATUS_EMPTY: n_empty++;
					STATUS_SHORT: n_short++;
					default: ;
					endcase
					if (int'(want.fill) > peak_fill) begin
						peak_fill = int'(want.fill);
					end
				end
			end
			if (in_valid && in_ready) begin
				n = apply_store_op(in_data);
				n_ops++;
				if (in_data.mode == MODE_PRINT) begin
					n_print++;
				end
				if (pin_on) begin
					owed_results.push_back(pin_res);
				end else begin
					for (int i = 0; i < n; i++) begin
						owed_results.push_back(step_res[i]);
					end
				end
			end
		end
	end

	function automatic dir_row_t fixed_row(input logic [2:0] mode, input logic [31:0] value,
			input logic [31:0] data, input logic [1:0] status, input logic [6:0] fill);
		dir_row_t r;
		r.op.mode = mode;
		r.op.value = value;
		r.pinned = 1'b1;
		r.res.data = data;
		r.res.status = status;
		r.res.last = 1'b1;
		r.res.fill = fill;
		return r;
	endfunction

	function automatic dir_row_t free_row(input logic [2:0] mode, input logic [31:0] value);
		dir_row_t r;
		r = '0;
		r.op.mode = mode;
		r.op.value = value;
		return r;
	endfunction

	function automatic dir_row_t dir_row(input int k);
		case (k)
		0: return fixed_row(MODE_POP, 32'h0, 32'h0, STATUS_EMPTY, 7'd0);
		1: return fixed_row(MODE_PEEK, 32'hFFFF_FFFF, 32'h0, STATUS_EMPTY, 7'd0);
		2: return fixed_row(MODE_SWAP, 32'h0, 32'h0, STATUS_SHORT, 7'd0);
		3: return free_row(MODE_PRINT, 32'h0);
		4: return fixed_row(MODE_UNUSED_LO, 32'h1234_5678, 32'h0, STATUS_OK, 7'd0);
		5: return fixed_row(MODE_UNUSED_HI, 32'hFFFF_FFFF, 32'h0, STATUS_OK, 7'd0);
		6: return fixed_row(MODE_PUSH, 32'h7FFF_FFFF, 32'h0, STATUS_OK, 7'd1);
		7: return fixed_row(MODE_SWAP, 32'h0, 32'h0, STATUS_SHORT, 7'd1);
		8: return fixed_row(MODE_PEEK, 32'h0, 32'h7FFF_FFFF, STATUS_OK, 7'd1);
		9: return fixed_row(MODE_PUSH, 32'h8000_0000, 32'h0, STATUS_OK, 7'd2);
		10: return fixed_row(MODE_PEEK, 32'h0, 32'h8000_0000, STATUS_OK, 7'd2);
		11: return fixed_row(MODE_SWAP, 32'h0, 32'h0, STATUS_OK, 7'd2);
		12: return fixed_row(MODE_PEEK, 32'h0, 32'h7FFF_FFFF, STATUS_OK, 7'd2);
		13: return fixed_row(MODE_PUSH, 32'hFFFF_FFFF, 32'h0, STATUS_OK, 7'd3);
		14: return fixed_row(MODE_PUSH, 32'h0, 32'h0, STATUS_OK, 7'd4);
		15: return free_row(MODE_PRINT, 32'hFFFF_FFFF);
		16: return fixed_row(MODE_UNUSED_MID, 32'h8000_0001, 32'h0, STATUS_OK, 7'd4);
		17: return fixed_row(MODE_POP, 32'h0, 32'h0, STATUS_OK, 7'd3);
		18: return free_row(MODE_PEEK, 32'h0);
		19: return fixed_row(MODE_POP, 32'h0, 32'h0, STATUS_OK, 7'd2);
		20: return fixed_row(MODE_POP, 32'h0, 32'h0, STATUS_OK, 7'd1);
		21: return fixed_row(MODE_POP, 32'h0, 32'h0, STATUS_OK, 7'd0);
		22: return fixed_row(MODE_PEEK, 32'h0, 32'h0, STATUS_EMPTY, 7'd0);
		23: return free_row(MODE_PUSH, 32'h5A5A_5A5A);
		default: return free_row(MODE_PRINT, 32'h0);
		endcase
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 7))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return 32'h0;
		3: return 32'hFFFF_FFFF;
		default: return $urandom();
		endcase
	endfunction

	function automatic sqe_in_t rand_op(input int w_push, input int w_pop);
		sqe_in_t op;
		int r;
		r = $urandom_range(0, 99);
		op.value = rand_value();
		if (r < w_push) begin
			op.mode = MODE_PUSH;
		end else if (r < w_push + w_pop) begin
			op.mode = MODE_POP;
		end else begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3: op.mode = MODE_PEEK;
			4, 5, 6: op.mode = MODE_SWAP;
			7, 8: op.mode = MODE_PRINT;
			default: op.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
			endcase
		end
		return op;
	endfunction

	// Starts at a falling edge and returns at the falling edge after the transaction.
	task automatic send_op(input sqe_in_t op, input logic pinned, input sqe_out_t res);
		int gap;
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pin_on = pinned;
		pin_res = res;
		in_data = op;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// An empty print-all owes no result, so the task waits the given extra cycles after the last one arrives.
	task automatic wait_quiet(input int extra);
		in_valid = 1'b0;
		while (owed_results.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic run_phase(input logic order, input int count, input int w_push,
			input int w_pop, input bit in_idle, input bit out_idle);
		sqe_out_t none;
		none = '0;
		wait_quiet(QUIET_CYCLES);
		cfg_wdata = order;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		src_idle = in_idle;
		sink_idle = out_idle;
		repeat (count) send_op(rand_op(w_push, w_pop), 1'b0, none);
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = sink_idle ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		dir_row_t row;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		pin_on = 1'b0;
		pin_res = '0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		shadow_front = '0;
		shadow_count = '0;
		shadow_queue_order = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int k = 0; k < NUM_DIR; k++) begin
			row = dir_row(k);
			send_op(row.op, row.pinned, row.res);
		end
		run_phase(1'b1, 100, 90, 3, 1'b1, 1'b1);
		run_phase(1'b0, 100, 35, 30, 1'b1, 1'b1);
		run_phase(1'b1, 90, 10, 60, 1'b1, 1'b0);
		run_phase(1'b0, 80, 40, 30, 1'b0, 1'b0);
		run_phase(1'b1, 80, 40, 35, 1'b0, 1'b1);
		wait_quiet(TAIL_CYCLES);
		$display("Ran %0d operations in stack and queue order, %0d results checked, peak fill %0d.",
			n_ops, n_results, peak_fill);
		$display("Statuses seen: %0d full, %0d empty, %0d short; %0d print-all operations.",
			n_full, n_empty, n_short, n_print);
		if (n_bad == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

endmodule
